// ===== rtl/core/sha256_pkg.sv =====
package sha256_pkg;

  typedef logic [31:0] word_t;

  // Working variables and chaining words, index 0 is the first word (a / H0).
  typedef logic [7:0][31:0] hstate_t;

  // Control from the sequencer to the round unit.
  typedef struct packed {
    logic       shift_byte;
    logic       init;
    logic       step;
    logic [5:0] rnd;
  } rnd_ctrl_t;

  localparam logic [7:0] PadMark   = 8'h80;
  localparam logic [5:0] LenPos    = 6'd56;
  localparam logic [5:0] LastRound = 6'd63;
  localparam logic [6:0] LoadLast  = 7'd64;
  localparam logic [2:0] LastWord  = 3'd7;

  localparam hstate_t InitHash = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

// ===== rtl/core/sha256_in_if.sv =====
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       start_message;
  logic       finish_message;

  modport source (
    output valid, data_byte, has_byte, start_message, finish_message,
    input  ready
  );
  modport sink (
    input  valid, data_byte, has_byte, start_message, finish_message,
    output ready
  );
endinterface

// ===== rtl/core/sha256_out_if.sv =====
interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (
    output valid, digest_word, word_index, last_word,
    input  ready
  );
  modport sink (
    input  valid, digest_word, word_index, last_word,
    output ready
  );
endinterface

// ===== rtl/core/sha256_hash.sv =====
// Channel   Dir   Beat contents
// msg       in    data_byte, has_byte, start_message, finish_message
// dig       out   digest_word, word_index, last_word (eight beats per digest)
//
// A byte that does not complete a block is taken without leaving the idle
// state, and the next beat may follow in the cycle after. A full block then
// passes the load state, streaming the 64 buffered bytes out of the buffer
// RAM into the schedule window, a set-up state, the 64 rounds of the shared
// round unit and the chaining add. A finish adds one or two padded blocks
// and then eight output beats. Reset is synchronous; it restores the initial
// hash values and clears both counts, the buffer RAM is left as it is. While
// reset is held, a block is compressed or a digest is waiting, msg is held
// not ready.
module sha256_hash (
  input  logic  clk,
  input  logic  rst,
  sha256_in_if.sink    msg,
  sha256_out_if.source dig
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOAD  = 6'b000010,
    S_PREP  = 6'b000100,
    S_ROUND = 6'b001000,
    S_FINAL = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t                state;
  sha256_pkg::hstate_t   chain;      // chaining words of the message so far
  sha256_pkg::hstate_t   dg;         // digest under construction
  sha256_pkg::hstate_t   base;
  sha256_pkg::hstate_t   vars;
  sha256_pkg::hstate_t   sum;
  sha256_pkg::rnd_ctrl_t ctrl;
  logic [5:0]            fill;
  logic [60:0]           byte_count;
  logic                  pad_mode;   // compressing a padded copy, not the buffer
  logic                  second;     // second of two padded blocks
  logic                  fin_pend;   // finish waits behind a full block
  logic [6:0]            ld_cnt;
  logic [5:0]            rnd;
  logic [2:0]            widx;
  logic                  accept;
  logic [5:0]            fill_eff;
  logic [5:0]            fill_next;
  logic                  blk_full;
  logic [7:0]            rdata;
  logic [7:0]            ld_byte;
  logic [5:0]            p;
  logic                  two_blk;
  logic [63:0]           bit_len;
  logic [7:0]            len_byte;

  assign msg.ready = (state == S_IDLE) && !rst;
  assign accept    = msg.valid && msg.ready;

  // Start is applied before the byte goes in, so the write lands at entry 0.
  assign fill_eff  = msg.start_message ? 6'd0 : fill;
  assign fill_next = fill_eff + 6'(msg.has_byte);
  assign blk_full  = msg.has_byte && (fill_eff == 6'd63);

  sha256_ram #(
    .Width (8),
    .Depth (64)
  ) u_buf (
    .clk   (clk),
    .we    (accept && msg.has_byte),
    .waddr (fill_eff),
    .wdata (msg.data_byte),
    .raddr (ld_cnt[5:0]),
    .rdata (rdata)
  );

  // The RAM read is registered, so the byte arriving now belongs to the
  // address issued in the previous cycle.
  assign p        = 6'(ld_cnt - 7'd1);
  assign two_blk  = (fill >= sha256_pkg::LenPos);
  assign bit_len  = {byte_count, 3'b000};
  assign len_byte = bit_len[{~p[2:0], 3'b000} +: 8];

  // Padding is formed on the fly: buffered bytes, the marker byte, zeros,
  // and the big-endian bit length in the last eight bytes of the final block.
  always_comb begin
    if (!pad_mode) begin
      ld_byte = rdata;
    end else if (!second && (p < fill)) begin
      ld_byte = rdata;
    end else if (!second && (p == fill)) begin
      ld_byte = sha256_pkg::PadMark;
    end else if ((p >= sha256_pkg::LenPos) && (second == two_blk)) begin
      ld_byte = len_byte;
    end else begin
      ld_byte = 8'h00;
    end
  end

  always_comb begin
    ctrl.shift_byte = (state == S_LOAD) && (ld_cnt != 7'd0);
    ctrl.init       = (state == S_PREP);
    ctrl.step       = (state == S_ROUND);
    ctrl.rnd        = rnd;
  end

  sha256_round u_round (
    .clk     (clk),
    .ctrl    (ctrl),
    .byte_in (ld_byte),
    .base    (base),
    .vars    (vars)
  );

  // The second padded block continues from the first, never from the
  // chaining words, which stay untouched so that the message can go on.
  assign base = (pad_mode && second) ? dg : chain;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      sum[i] = base[i] + vars[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      chain      <= sha256_pkg::InitHash;
      fill       <= 6'd0;
      byte_count <= '0;
      pad_mode   <= 1'b0;
      second     <= 1'b0;
      fin_pend   <= 1'b0;
      ld_cnt     <= 7'd0;
      rnd        <= 6'd0;
      widx       <= 3'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (msg.start_message) begin
              chain <= sha256_pkg::InitHash;
            end
            fill       <= fill_next;
            byte_count <= (msg.start_message ? 61'd0 : byte_count) + 61'(msg.has_byte);
            fin_pend   <= msg.finish_message;
            ld_cnt     <= 7'd0;
            second     <= 1'b0;
            if (blk_full) begin
              pad_mode <= 1'b0;
              state    <= S_LOAD;
            end else if (msg.finish_message) begin
              pad_mode <= 1'b1;
              state    <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          ld_cnt <= ld_cnt + 7'd1;
          if (ld_cnt == sha256_pkg::LoadLast) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          rnd   <= 6'd0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          rnd <= rnd + 6'd1;
          if (rnd == sha256_pkg::LastRound) begin
            state <= S_FINAL;
          end
        end
        S_FINAL: begin
          ld_cnt <= 7'd0;
          if (!pad_mode) begin
            chain <= sum;
            if (fin_pend) begin
              fin_pend <= 1'b0;
              pad_mode <= 1'b1;
              second   <= 1'b0;
              state    <= S_LOAD;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            dg <= sum;
            if (!second && two_blk) begin
              second <= 1'b1;
              state  <= S_LOAD;
            end else begin
              widx  <= 3'd0;
              state <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (dig.ready) begin
            widx <= widx + 3'd1;
            if (widx == sha256_pkg::LastWord) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign dig.valid       = (state == S_EMIT);
  assign dig.digest_word = dg[widx];
  assign dig.word_index  = widx;
  assign dig.last_word   = (widx == sha256_pkg::LastWord);

`ifndef NO_ASSERTIONS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(msg.ready && dig.valid))
    else $error("input taken while a digest is being delivered");

  a_last_drop: assert property (@(posedge clk) disable iff (rst)
    (dig.valid && dig.ready && dig.last_word) |=> !dig.valid)
    else $error("digest beats continue after the last word");

  a_round_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && rnd == sha256_pkg::LastRound) |=> (state == S_FINAL))
    else $error("compression did not end after the last round");

  a_fin_pad: assert property (@(posedge clk) disable iff (rst)
    (accept && msg.finish_message && !blk_full) |=>
      (state == S_LOAD && pad_mode && !second))
    else $error("finish without a full block did not start padding");

  a_chain_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINAL && pad_mode) |=> $stable(chain))
    else $error("chaining words altered by a padded block");
`endif

endmodule

// ===== rtl/core/sha256_ram.sv =====
module sha256_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/sha256_round.sv =====
module sha256_round (
  input  logic                clk,
  input  sha256_pkg::rnd_ctrl_t ctrl,
  input  logic [7:0]          byte_in,
  input  sha256_pkg::hstate_t base,
  output sha256_pkg::hstate_t vars
);

  // Sixteen-word schedule window; ws[15] is the oldest word, the one used now.
  logic [15:0][31:0]   ws;
  sha256_pkg::hstate_t v;
  sha256_pkg::word_t   hkw;
  sha256_pkg::word_t   big0, big1, ch, maj, t1, w_new, sig0, sig1;
  logic [5:0]          rnd_nx;

  function automatic sha256_pkg::word_t rotr(input sha256_pkg::word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  always_comb begin
    big1   = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
    ch     = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1     = hkw + big1 + ch;
    big0   = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
    maj    = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    sig0   = rotr(ws[14], 7) ^ rotr(ws[14], 18) ^ (ws[14] >> 3);
    sig1   = rotr(ws[1], 17) ^ rotr(ws[1], 19) ^ (ws[1] >> 10);
    w_new  = ws[15] + sig0 + ws[6] + sig1;
    rnd_nx = ctrl.rnd + 6'd1;
  end

  // The h + K + W term of the next round is summed and registered during the
  // current round, since next round's h is this round's g.
  always_ff @(posedge clk) begin
    if (ctrl.shift_byte) begin
      ws <= {ws[15][23:0], ws[14:0], byte_in};
    end else if (ctrl.init) begin
      v   <= base;
      hkw <= base[7] + sha256_pkg::RoundK[0] + ws[15];
    end else if (ctrl.step) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + big0 + maj;
      hkw  <= v[6] + sha256_pkg::RoundK[rnd_nx] + ws[14];
      ws   <= {ws[14:0], w_new};
    end
  end

  assign vars = v;

endmodule
